// File: rtl/core/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pnc_pkg
// Shared types, constants and helpers for the peak normaliser with clamp.
// ----------------------------------------------------------------------------
package pnc_pkg;

  localparam int SAMPLE_W      = 24;
  localparam int PEAK_W        = 23;
  localparam int BITS_W        = 5;
  localparam int RATIO_W       = 17;
  localparam int CLIP_W        = 32;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam int QUEUE_DEPTH_D = 4;

  localparam logic [RATIO_W-1:0] DEFAULT_RATIO = 17'd62259;
  localparam logic [RATIO_W-1:0] FULL_RATIO    = 17'd65536;
  localparam logic [BITS_W-1:0]  RESET_BITS    = 5'd16;
  localparam logic [BITS_W-1:0]  MIN_BITS      = 5'd8;
  localparam logic [BITS_W-1:0]  MAX_BITS      = 5'd24;

  // Register index, taken from paddr[2]
  localparam logic REG_SAMPLE_BITS  = 1'b0;
  localparam logic REG_TARGET_RATIO = 1'b1;

  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_APPLY   = 1'b1;

  typedef struct packed {
    logic                mode;
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] raw;
    logic                last;
  } item_t;

  // Full-scale peak: 2^(bits-1)-1, bits held to 8..24
  function automatic logic [PEAK_W-1:0] peak_of(input logic [BITS_W-1:0] bits);
    logic [BITS_W-1:0] b;
    logic [PEAK_W:0]   one_hot;
    b = bits;
    if (b < MIN_BITS) b = MIN_BITS;
    if (b > MAX_BITS) b = MAX_BITS;
    one_hot = '0;
    one_hot[b - 5'd1] = 1'b1;
    return PEAK_W'(one_hot - 1'b1);
  endfunction

  function automatic logic [RATIO_W-1:0] ratio_of(input logic [RATIO_W-1:0] r);
    if (r == '0 || r > FULL_RATIO) return DEFAULT_RATIO;
    return r;
  endfunction

endpackage

// File: rtl/core/peak_normalizer_with_clamp_top.sv
// ----------------------------------------------------------------------------
// peak_normalizer_with_clamp_top
// Two-pass peak normaliser with clamp, APB register port.
// ----------------------------------------------------------------------------
// Each block of signed samples is streamed in twice on the in_ channel:
// first with in_mode = 0 (measure, peak tracking), then with in_mode = 1
// (apply, scaling to the target ratio of full scale with clamping).
// in_last marks the final sample of a pass. The out_ channel carries one
// result per apply sample and one for the last measure sample.
// Transfers happen when valid is high and stall is low.
// A four-entry queue sits behind the input, so the sender can run ahead.
// An apply item passes through pop, classify, two multiply steps, a 48-step
// restoring divide (one quotient bit per cycle), clamp and emit. A measure
// item is popped and classified, and emitted only with in_last. Passthrough
// (silent block) skips the multiplies and the divide. The back end takes the
// next item only once it is through with the last one.
// The result register holds its value while out_stall is high; the back end
// waits on it, and the input stalls once the queue fills.
// Reset clears the queue, the statistics and sets the new-block flag;
// sample_bits returns to 16 and target_ratio to 62259.
// Registers (psel/penable write, pready always high): 0x0 sample_bits,
// 0x4 target_ratio.
// ----------------------------------------------------------------------------
module peak_normalizer_with_clamp_top import pnc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_scaled,
  output logic                out_clipped,
  output logic                out_final_res,
  output logic [SAMPLE_W-1:0] out_peak_before,
  output logic [PEAK_W-1:0]   out_peak_after,
  output logic [CLIP_W-1:0]   out_clip_count
);

  logic [BITS_W-1:0]  bits_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [PEAK_W-1:0]  peak_r;
  logic [RATIO_W-1:0] ratio_eff_r;
  logic               wr_en;
  logic               q_valid;
  logic               q_pop;
  item_t              q_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_SAMPLE_BITS:  prdata = PDATA_W'(bits_r);
      REG_TARGET_RATIO: prdata = PDATA_W'(ratio_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r  <= RESET_BITS;
      ratio_r <= DEFAULT_RATIO;
    end else if (wr_en) begin
      if (paddr[2] == REG_SAMPLE_BITS) bits_r  <= pwdata[BITS_W-1:0];
      else                             ratio_r <= pwdata[RATIO_W-1:0];
    end
  end

  // decoded settings, registered off the multiply path
  always_ff @(posedge clk) begin
    peak_r      <= peak_of(bits_r);
    ratio_eff_r <= ratio_of(ratio_r);
  end

  pnc_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_sample (in_sample),
    .in_last   (in_last),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  pnc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .peak            (peak_r),
    .ratio           (ratio_eff_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_scaled      (out_scaled),
    .out_clipped     (out_clipped),
    .out_final_res   (out_final_res),
    .out_peak_before (out_peak_before),
    .out_peak_after  (out_peak_after),
    .out_clip_count  (out_clip_count)
  );

endmodule

// File: rtl/core/pnc_front.sv
// ----------------------------------------------------------------------------
// pnc_front
// Takes input transfers, splits each sample into sign and magnitude and
// queues the item for the back end.
// ----------------------------------------------------------------------------
module pnc_front import pnc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_last,
  output logic                q_valid,
  output item_t               q_item,
  input  logic                q_pop
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  item_t          cls;
  logic           push;
  logic           pop;

  always_comb begin
    cls.mode = in_mode;
    cls.neg  = in_sample[SAMPLE_W-1];
    cls.raw  = in_sample;
    cls.last = in_last;
    // most negative value keeps magnitude 2^23 exactly
    cls.mag  = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
  end

  assign in_stall = (count_r == CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: rtl/core/pnc_back.sv
// ----------------------------------------------------------------------------
// pnc_back
// Executes queued items in order: peak tracking, scaling by two registered
// multiplies and a restoring divider, clamping, statistics and result
// register.
// ----------------------------------------------------------------------------
module pnc_back import pnc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  item_t               q_item,
  output logic                q_pop,
  input  logic [PEAK_W-1:0]   peak,
  input  logic [RATIO_W-1:0]  ratio,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_scaled,
  output logic                out_clipped,
  output logic                out_final_res,
  output logic [SAMPLE_W-1:0] out_peak_before,
  output logic [PEAK_W-1:0]   out_peak_after,
  output logic [CLIP_W-1:0]   out_clip_count
);

  localparam int PROD_W = SAMPLE_W + PEAK_W;
  localparam int NUM_W  = 64;
  localparam int DIV_W  = NUM_W - 16;
  localparam int CNT_W  = $clog2(DIV_W);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_MUL1 = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  item_t               item_r, item_nxt;
  logic [SAMPLE_W-1:0] max_in_r, max_in_nxt;
  logic [PEAK_W-1:0]   max_out_r, max_out_nxt;
  logic [CLIP_W-1:0]   clip_r, clip_nxt;
  logic                blk_start_r, blk_start_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [DIV_W-1:0]    dvd_r, dvd_nxt;
  logic [SAMPLE_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] res_scaled_r, res_scaled_nxt;
  logic                res_clip_r, res_clip_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [NUM_W-1:0]    num;
  logic [SAMPLE_W:0]   trial;
  logic [SAMPLE_W:0]   trial_sub;
  logic [SAMPLE_W-1:0] base_in;
  logic [PEAK_W-1:0]   q_clamped;
  logic                out_load;

  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    max_in_nxt     = max_in_r;
    max_out_nxt    = max_out_r;
    clip_nxt       = clip_r;
    blk_start_nxt  = blk_start_r;
    prod_nxt       = prod_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    res_scaled_nxt = res_scaled_r;
    res_clip_nxt   = res_clip_r;
    base_in        = blk_start_r ? '0 : max_in_r;
    num            = NUM_W'(prod_r) * NUM_W'(ratio) + (NUM_W'(max_in_r) << 15);
    trial          = {rem_r, dvd_r[DIV_W-1]};
    trial_sub      = trial - {1'b0, max_in_r};
    q_clamped      = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          item_nxt  = q_item;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // first item of a block clears the statistics
        if (blk_start_r) begin
          max_out_nxt = '0;
          clip_nxt    = '0;
        end
        blk_start_nxt  = 1'b0;
        max_in_nxt     = base_in;
        res_scaled_nxt = '0;
        res_clip_nxt   = 1'b0;
        if (item_r.mode == MODE_MEASURE) begin
          if (item_r.mag > base_in) max_in_nxt = item_r.mag;
          state_nxt = item_r.last ? ST_EMIT : ST_IDLE;
        end else if (base_in == '0) begin
          res_scaled_nxt = item_r.raw;
          if (item_r.last) blk_start_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        prod_nxt  = PROD_W'(item_r.mag) * PROD_W'(peak);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        // round half up: (num + den/2) / den, den = max_in * 2^16
        dvd_nxt   = num[NUM_W-1:16];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!trial_sub[SAMPLE_W]) begin
          rem_nxt = trial_sub[SAMPLE_W-1:0];
          dvd_nxt = {dvd_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[SAMPLE_W-1:0];
          dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // dvd_r now holds the quotient
        if (dvd_r > DIV_W'(peak)) begin
          q_clamped    = peak;
          res_clip_nxt = 1'b1;
          if (clip_r != '1) clip_nxt = clip_r + 1'b1;
        end else begin
          q_clamped = dvd_r[PEAK_W-1:0];
        end
        if (q_clamped > max_out_r) max_out_nxt = q_clamped;
        res_scaled_nxt = item_r.neg ? (~{1'b0, q_clamped} + 1'b1) : {1'b0, q_clamped};
        if (item_r.last) blk_start_nxt = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load)                      out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else                               out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_in_r    <= '0;
      max_out_r   <= '0;
      clip_r      <= '0;
      blk_start_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_in_r    <= max_in_nxt;
      max_out_r   <= max_out_nxt;
      clip_r      <= clip_nxt;
      blk_start_r <= blk_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    prod_r       <= prod_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    res_scaled_r <= res_scaled_nxt;
    res_clip_r   <= res_clip_nxt;
    if (out_load) begin
      out_scaled      <= res_scaled_r;
      out_clipped     <= res_clip_r;
      out_final_res   <= item_r.last;
      out_peak_before <= max_in_r;
      out_peak_after  <= max_out_r;
      out_clip_count  <= clip_r;
    end
  end

endmodule

// File: bench/peak_normalizer_with_clamp_top_tb.sv
// ----------------------------------------------------------------------------
// peak_normalizer_with_clamp_top_tb
// Self-checking bench for the two-pass peak normaliser with clamp.
// ----------------------------------------------------------------------------
// A table of directed transfers covers reset defaults, sample extremes,
// silent blocks, apply without measure and measure inside apply. Random
// blocks follow: a measure pass and an apply pass over the same samples,
// with some noise items, under several register settings and idling phases.
// Every result is checked against a predictor of the scaling arithmetic.
// ----------------------------------------------------------------------------
module peak_normalizer_with_clamp_top_tb;
  import pnc_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 120;

  typedef struct {
    logic [SAMPLE_W-1:0] scaled;
    logic                clipped;
    logic                final_res;
    logic [SAMPLE_W-1:0] peak_before;
    logic [PEAK_W-1:0]   peak_after;
    logic [CLIP_W-1:0]   clip_count;
    bit                  fixed;   // directed row with hand-typed result
  } norm_result_t;

  typedef struct {
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    bit                  fixed;
    logic [SAMPLE_W-1:0] scaled;
    logic [SAMPLE_W-1:0] peak_before;
  } vec_t;

  logic                clk;
  logic                rst_n;
  logic                psel, penable, pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid, in_stall, in_mode, in_last;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_valid, out_stall;
  logic [SAMPLE_W-1:0] out_scaled;
  logic                out_clipped, out_final_res;
  logic [SAMPLE_W-1:0] out_peak_before;
  logic [PEAK_W-1:0]   out_peak_after;
  logic [CLIP_W-1:0]   out_clip_count;

  peak_normalizer_with_clamp_top DUT (.*);

  // predictor state
  logic [BITS_W-1:0]  bits_reg;
  logic [RATIO_W-1:0] ratio_reg;
  logic [SAMPLE_W-1:0] max_in_q;
  logic [SAMPLE_W-1:0] max_out_q;
  logic [CLIP_W-1:0]  clip_total_q;
  bit                 new_block;

  norm_result_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_clipped = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  vec_t pending_vec;
  bit   pending_on = 0;
  bit   timed_out = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SAMPLE_W-1:0] full_scale();
    int b;
    b = bits_reg;
    if (b < 8) b = 8;
    if (b > 24) b = 24;
    return SAMPLE_W'((64'd1 << (b - 1)) - 1);
  endfunction

  function automatic longint unsigned gain_ratio();
    if (ratio_reg == 0 || ratio_reg > 17'd65536) return 62259;
    return ratio_reg;
  endfunction

  // returns 1 when the item yields a result
  function automatic bit normalise(input logic mode, input logic [SAMPLE_W-1:0] raw,
                                   input logic last, output norm_result_t r);
    bit neg;
    logic [SAMPLE_W:0] mag;
    longint unsigned pk, num, den, q;
    neg = raw[SAMPLE_W-1];
    mag = neg ? (25'h1000000 - {1'b0, raw}) : {1'b0, raw};
    r = '{default: '0};
    if (new_block) begin
      max_in_q = '0; max_out_q = '0; clip_total_q = '0; new_block = 0;
    end
    if (mode == MODE_MEASURE) begin
      if (mag > max_in_q) max_in_q = SAMPLE_W'(mag);
      if (!last) return 0;
    end else begin
      if (max_in_q == 0 && mag != 25'h1000000) r.scaled = raw;
      else if (max_in_q == 0) r.scaled = raw;
      else begin
        pk = full_scale();
        num = longint'(mag) * pk * gain_ratio();
        den = (max_in_q == 0 ? 64'd1 << 24 : longint'(max_in_q)) << 16;
        q = (2 * num + den) / (2 * den);
        if (q > pk) begin
          q = pk;
          r.clipped = 1;
          if (clip_total_q != '1) clip_total_q++;
        end
        if (q > max_out_q) max_out_q = SAMPLE_W'(q);
        r.scaled = neg ? SAMPLE_W'(25'h1000000 - q) : SAMPLE_W'(q);
      end
      if (last) new_block = 1;
    end
    r.final_res   = last;
    r.peak_before = max_in_q;
    r.peak_after  = PEAK_W'(max_out_q);
    r.clip_count  = clip_total_q;
    return 1;
  endfunction

  task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_SAMPLE_BITS) bits_reg = val[BITS_W-1:0];
    else ratio_reg = val[RATIO_W-1:0];
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // hands one item to the driver and waits until it is taken;
  // valid stays up after the transfer until the next item or an idle cycle
  task automatic send(input vec_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    pending_vec = v;
    pending_on = 1;
    in_valid <= 1; in_mode <= v.mode; in_sample <= v.sample; in_last <= v.last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // accepted input -> predictor
  always @(posedge clk) begin
    norm_result_t r;
    if (rst_n && in_valid && !in_stall && pending_on) begin
      if (normalise(pending_vec.mode, pending_vec.sample, pending_vec.last, r)) begin
        r.fixed = pending_vec.fixed;
        if (pending_vec.fixed) begin
          r.scaled = pending_vec.scaled;
          r.peak_before = pending_vec.peak_before;
        end
        expected_q.push_back(r);
      end
    end
  end

  always @(posedge clk) begin
    norm_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with none expected: scaled %0h", out_scaled);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_clipped) n_clipped++;
        if (out_scaled !== e.scaled) begin
          $error("scaled exp %0h got %0h", e.scaled, out_scaled); errors++;
        end
        if (out_clipped !== e.clipped) begin
          $error("clipped exp %0h got %0h", e.clipped, out_clipped); errors++;
        end
        if (out_final_res !== e.final_res) begin
          $error("final_res exp %0h got %0h", e.final_res, out_final_res); errors++;
        end
        if (out_peak_before !== e.peak_before) begin
          $error("peak_before exp %0h got %0h", e.peak_before, out_peak_before);
          errors++;
        end
        if (out_peak_after !== e.peak_after) begin
          $error("peak_after exp %0h got %0h", e.peak_after, out_peak_after); errors++;
        end
        if (out_clip_count !== e.clip_count) begin
          $error("clip_count exp %0h got %0h", e.clip_count, out_clip_count); errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic vec_t mk(input logic mode, input int s, input logic last);
    vec_t v;
    v = '{default: '0};
    v.mode = mode; v.sample = SAMPLE_W'(s); v.last = last;
    return v;
  endfunction

  function automatic vec_t mkx(input logic mode, input int s, input logic last,
                               input int sc, input int pb);
    vec_t v;
    v = mk(mode, s, last);
    v.fixed = 1; v.scaled = SAMPLE_W'(sc); v.peak_before = SAMPLE_W'(pb);
    return v;
  endfunction

  // called at a falling edge right after the last send
  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_block(input int len);
    int samp[$];
    int amp;
    amp = 1 << $urandom_range(23);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) samp.push_back(int'($urandom()) >>> 8);
      else samp.push_back($urandom_range(2 * amp) - amp);
    end
    for (int i = 0; i < len; i++) send(mk(MODE_MEASURE, samp[i], i == len - 1));
    for (int i = 0; i < len; i++) begin
      // occasional stray measure item inside the apply pass
      if ($urandom_range(29) == 0) send(mk(MODE_MEASURE, int'($urandom()) >>> 8, 0));
      send(mk(MODE_APPLY, samp[i], i == len - 1));
    end
  endtask

  initial begin
    vec_t dir_tab[$];
    int sent;
    int bit_choices[6] = '{8, 0, 24, 31, 12, 16};
    int ratio_choices[6] = '{65536, 0, 1, 131071, 40000, 62259};
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; in_mode = 0; in_sample = '0; in_last = 0; out_stall = 0;
    bits_reg = 5'd16; ratio_reg = 17'd62259;
    max_in_q = '0; max_out_q = '0; clip_total_q = '0; new_block = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // apply without measure passes through; silent block; extremes
    dir_tab.push_back(mkx(MODE_APPLY, -8388608, 1, -8388608, 0));
    dir_tab.push_back(mkx(MODE_MEASURE, 0, 1, 0, 0));
    dir_tab.push_back(mkx(MODE_APPLY, 0, 1, 0, 0));
    dir_tab.push_back(mk(MODE_MEASURE, 8388607, 0));
    dir_tab.push_back(mkx(MODE_MEASURE, -8388608, 1, 0, 8388608));
    dir_tab.push_back(mk(MODE_APPLY, 8388607, 0));
    dir_tab.push_back(mk(MODE_APPLY, -8388608, 0));
    dir_tab.push_back(mk(MODE_APPLY, 1, 0));
    dir_tab.push_back(mk(MODE_APPLY, -1, 0));
    dir_tab.push_back(mk(MODE_APPLY, 0, 1));
    dir_tab.push_back(mk(MODE_MEASURE, 100, 0));
    dir_tab.push_back(mkx(MODE_MEASURE, -200, 1, 0, 200));
    dir_tab.push_back(mk(MODE_APPLY, 200, 0));
    // measure inside apply raises the peak to 400: -400 no longer clips, 5555 does
    dir_tab.push_back(mk(MODE_MEASURE, 400, 0));
    dir_tab.push_back(mk(MODE_APPLY, -400, 0));
    dir_tab.push_back(mk(MODE_APPLY, 5555, 1));
    foreach (dir_tab[i]) send(dir_tab[i]);
    drain();

    sent = 0;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      reg_write(REG_SAMPLE_BITS, bit_choices[ph % 6]);
      reg_write(REG_TARGET_RATIO, ratio_choices[(ph + ph / 6) % 6]);
      while (sent < (ph + 1) * 92) begin
        int len;
        len = $urandom_range(1, 12);
        random_block(len);
        sent += 2 * len;
      end
      drain();
      recv_stall_pct = 0;
    end

    $display("Checked %0d results (%0d clamped) over directed rows and %0d random items",
             n_results, n_clipped, sent);
    if (errors == 0 && expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
